/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* hw/rtl/vrfc_pkg.sv */
// Shared types and constants of the voxel row face culler.
`timescale 1ns / 1ps

package vrfc_pkg;

   // Field widths
   localparam int ROW_BITS       = 18;
   localparam int COORD_BITS     = 4;
   localparam int MASK_BITS      = 6;
   localparam int ROW_VOXELS_DEF = 16;

   // Beat widths, padded to whole bytes
   localparam int REQ_DATA_BITS = 104;
   localparam int RSP_DATA_BITS = 24;

   // Face mask bit positions
   localparam int FACE_X_LO = 0;
   localparam int FACE_X_HI = 1;
   localparam int FACE_Y_HI = 2;
   localparam int FACE_Y_LO = 3;
   localparam int FACE_Z_HI = 4;
   localparam int FACE_Z_LO = 5;

   // Opacity of one voxel and its six neighbors
   typedef struct packed {
      logic self_bit;
      logic left_bit;
      logic right_bit;
      logic above_bit;
      logic below_bit;
      logic ahead_bit;
      logic behind_bit;
   } nbr_type;

   // One result beat
   typedef struct packed {
      logic                  last;
      logic [MASK_BITS-1:0]  face_mask;
      logic [COORD_BITS-1:0] voxel_z;
      logic [COORD_BITS-1:0] voxel_y;
      logic [COORD_BITS-1:0] voxel_x;
   } beat_type;

endpackage

/* hw/rtl/voxel_row_face_culler_core.sv */
// Voxel row face culler: one beat per exposed voxel of an opacity row.
// A row beat is taken while the block is idle; ROW_VOXELS lanes form every voxel's face
// mask at once and the merge stage shifts them out one x position per cycle,
// unless an exposed voxel waits on a stalled result side, giving one result beat
// per opaque voxel with an exposed face, lowest x first, tlast on the final one.
// The next row is taken as soon as the shifter is empty, even if the last result
// beat still waits in the output register. Voxels above bit 17 of the row fields
// read as empty, and voxel_x wraps at 16.
`timescale 1ns / 1ps

module voxel_row_face_culler_core #(
   parameter int ROW_VOXELS = vrfc_pkg::ROW_VOXELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // row_center, row_y_above, row_y_below, row_z_ahead, row_z_behind, row_y, row_z
   input  logic [vrfc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // voxel_x, voxel_y, voxel_z, face_mask
   output logic [vrfc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);

   localparam int RowW     = ROW_VOXELS + 2;
   localparam int CopyBits = (RowW < vrfc_pkg::ROW_BITS) ? RowW : vrfc_pkg::ROW_BITS;
   localparam int RB       = vrfc_pkg::ROW_BITS;
   localparam int CB       = vrfc_pkg::COORD_BITS;

   logic [RowW-1:0] center, above, below, ahead, behind;
   logic [CB-1:0]   row_y, row_z;
   logic [ROW_VOXELS-1:0][vrfc_pkg::MASK_BITS-1:0] lane_mask;
   vrfc_pkg::beat_type rsp_beat;
   logic load, idle;

   // Unpack the row beat, resized to the row width
   always_comb begin
      center = '0;
      above  = '0;
      below  = '0;
      ahead  = '0;
      behind = '0;
      center[CopyBits-1:0] = req_tdata[0*RB +: CopyBits];
      above[CopyBits-1:0]  = req_tdata[1*RB +: CopyBits];
      below[CopyBits-1:0]  = req_tdata[2*RB +: CopyBits];
      ahead[CopyBits-1:0]  = req_tdata[3*RB +: CopyBits];
      behind[CopyBits-1:0] = req_tdata[4*RB +: CopyBits];
   end

   assign row_y = req_tdata[5*RB +: CB];
   assign row_z = req_tdata[5*RB+CB +: CB];

   // One lane per interior voxel
   for (genvar g = 0; g < ROW_VOXELS; g++) begin : g_lane
      vrfc_pkg::nbr_type nbr;
      assign nbr.self_bit   = center[g+1];
      assign nbr.left_bit   = center[g];
      assign nbr.right_bit  = center[g+2];
      assign nbr.above_bit  = above[g+1];
      assign nbr.below_bit  = below[g+1];
      assign nbr.ahead_bit  = ahead[g+1];
      assign nbr.behind_bit = behind[g+1];

      vrfc_lane u_lane (
         .nbr       (nbr),
         .face_mask (lane_mask[g])
      );
   end

   // Row handshake
   assign req_tready = idle;
   assign load       = req_tvalid & idle;

   vrfc_merge #(
      .LANES (ROW_VOXELS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .lane_mask (lane_mask),
      .row_y     (row_y),
      .row_z     (row_z),
      .idle      (idle),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_beat  (rsp_beat)
   );

   // Pack the result beat
   assign rsp_tdata = {{(vrfc_pkg::RSP_DATA_BITS - 3*CB - vrfc_pkg::MASK_BITS){1'b0}},
                       rsp_beat.face_mask, rsp_beat.voxel_z, rsp_beat.voxel_y,
                       rsp_beat.voxel_x};
   assign rsp_tlast = rsp_beat.last;

endmodule

/* hw/rtl/vrfc_lane.sv */
// One culling lane: exposed-face mask of a single voxel.
`timescale 1ns / 1ps

module vrfc_lane (
   input  vrfc_pkg::nbr_type                nbr,
   output logic [vrfc_pkg::MASK_BITS-1:0]   face_mask
);

   // A face is exposed when the voxel is opaque and the neighbor is not
   always_comb begin
      face_mask = '0;
      if (nbr.self_bit) begin
         face_mask[vrfc_pkg::FACE_X_LO] = ~nbr.left_bit;
         face_mask[vrfc_pkg::FACE_X_HI] = ~nbr.right_bit;
         face_mask[vrfc_pkg::FACE_Y_HI] = ~nbr.above_bit;
         face_mask[vrfc_pkg::FACE_Y_LO] = ~nbr.below_bit;
         face_mask[vrfc_pkg::FACE_Z_HI] = ~nbr.ahead_bit;
         face_mask[vrfc_pkg::FACE_Z_LO] = ~nbr.behind_bit;
      end
   end

endmodule

/* hw/rtl/vrfc_merge.sv */
// Merge stage: shifts lane masks out in ascending x, one beat per exposed voxel.
`timescale 1ns / 1ps

module vrfc_merge #(
   parameter int LANES = vrfc_pkg::ROW_VOXELS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       load,
   input  logic [LANES-1:0][vrfc_pkg::MASK_BITS-1:0]  lane_mask,
   input  logic [vrfc_pkg::COORD_BITS-1:0]            row_y,
   input  logic [vrfc_pkg::COORD_BITS-1:0]            row_z,
   output logic                                       idle,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output vrfc_pkg::beat_type                         rsp_beat
);

   logic [LANES-1:0]                             pend_ff, pend_in;
   logic [LANES-1:0][vrfc_pkg::MASK_BITS-1:0]    mask_ff, mask_in;
   logic [vrfc_pkg::COORD_BITS-1:0]              x_ff, x_in;
   logic [vrfc_pkg::COORD_BITS-1:0]              y_ff, y_in;
   logic [vrfc_pkg::COORD_BITS-1:0]              z_ff, z_in;
   logic                                         valid_ff, valid_in;
   vrfc_pkg::beat_type                           beat_ff, beat_in;

   logic busy, out_free, emit, advance;

   // Scan control
   assign busy     = |pend_ff;
   assign out_free = ~valid_ff | rsp_ready;
   assign emit     = busy & pend_ff[0] & out_free;
   assign advance  = busy & (~pend_ff[0] | out_free);

   // Shift line and row registers
   always_comb begin
      pend_in = pend_ff;
      mask_in = mask_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (load) begin
         for (int i = 0; i < LANES; i++) begin
            pend_in[i] = |lane_mask[i];
         end
         mask_in = lane_mask;
         x_in    = '0;
         y_in    = row_y;
         z_in    = row_z;
      end else if (advance) begin
         pend_in = pend_ff >> 1;
         for (int i = 0; i < LANES - 1; i++) begin
            mask_in[i] = mask_ff[i+1];
         end
         mask_in[LANES-1] = '0;
         x_in = x_ff + 1'b1;
      end
   end

   // Output register
   always_comb begin
      valid_in = valid_ff & ~rsp_ready;
      beat_in  = beat_ff;
      if (emit) begin
         valid_in          = 1'b1;
         beat_in.voxel_x   = x_ff;
         beat_in.voxel_y   = y_ff;
         beat_in.voxel_z   = z_ff;
         beat_in.face_mask = mask_ff[0];
         beat_in.last      = ~|pend_ff[LANES-1:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      beat_ff <= beat_in;
   end

   assign idle      = ~busy;
   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

/* hw/rtl/vrfc_checker.sv */
// Port-level checks of the voxel row face culler, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vrfc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic [vrfc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input logic                                 rsp_tlast,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);

   logic mask_zero;
   logic mid_row_beat;

   assign mask_zero    = rsp_tdata[17:12] == 6'd0;
   assign mid_row_beat = rsp_tvalid & ~rsp_tlast;

   // A result beat always carries at least one exposed face
   `ASSERT_IMPLY(a_mask_nonzero, clock, reset, rsp_tvalid, !mask_zero)
   // A mid-row beat is waiting, so more of the row remains and no row is taken
   `ASSERT_IMPLY(a_no_row_mid_beats, clock, reset, mid_row_beat, !req_tready)
   // A stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   // Reset empties the output register
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_tvalid)

endmodule

bind voxel_row_face_culler_core vrfc_checker u_vrfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

/* tb/sv/tb_voxel_row_face_culler_core.sv */
// Self-checking testbench for the voxel row face culler core.
`timescale 1ns / 1ps

module tb_voxel_row_face_culler_core;

   localparam int RB = vrfc_pkg::ROW_BITS;
   localparam int CB = vrfc_pkg::COORD_BITS;
   localparam logic [RB-1:0] ROW_FULL  = 18'h3FFFF;
   localparam logic [RB-1:0] ROW_EMPTY = 18'h00000;
   localparam int IDLE_PCT     = 29;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   // One row item as the sender sees it
   typedef struct packed {
      logic [RB-1:0] center;
      logic [RB-1:0] above;
      logic [RB-1:0] below;
      logic [RB-1:0] ahead;
      logic [RB-1:0] behind;
      logic [CB-1:0] y;
      logic [CB-1:0] z;
   } row_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   // row_center, row_y_above, row_y_below, row_z_ahead, row_z_behind, row_y, row_z
   logic [vrfc_pkg::REQ_DATA_BITS-1:0]   req_tdata;
   logic                                 req_tvalid;
   logic                                 req_tready;
   // voxel_x, voxel_y, voxel_z, face_mask
   logic [vrfc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                                 rsp_tlast;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready;

   vrfc_pkg::beat_type faces_due[$];
   int       fault_count   = 0;
   int       cycle_count   = 0;
   bit       tx_idle_on    = 1'b0;
   bit       rx_idle_on    = 1'b0;
   int       hold_requests = 0;
   int       hold_len      = 0;

   voxel_row_face_culler_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected beats of one row: one per opaque interior voxel with an open face
   function automatic void predict_faces(input row_type r);
      logic [RB-1:0]                  open_xlo, open_xhi, open_yhi;
      logic [RB-1:0]                  open_ylo, open_zhi, open_zlo;
      logic [vrfc_pkg::MASK_BITS-1:0] masks[vrfc_pkg::ROW_VOXELS_DEF+1];
      int                             last_bit;
      vrfc_pkg::beat_type             b;
      open_xlo = r.center & ~(r.center << 1);
      open_xhi = r.center & ~(r.center >> 1);
      open_yhi = r.center & ~r.above;
      open_ylo = r.center & ~r.below;
      open_zhi = r.center & ~r.ahead;
      open_zlo = r.center & ~r.behind;
      last_bit = 0;
      for (int i = 1; i <= vrfc_pkg::ROW_VOXELS_DEF; i++) begin
         masks[i] = '0;
         masks[i][vrfc_pkg::FACE_X_LO] = open_xlo[i];
         masks[i][vrfc_pkg::FACE_X_HI] = open_xhi[i];
         masks[i][vrfc_pkg::FACE_Y_HI] = open_yhi[i];
         masks[i][vrfc_pkg::FACE_Y_LO] = open_ylo[i];
         masks[i][vrfc_pkg::FACE_Z_HI] = open_zhi[i];
         masks[i][vrfc_pkg::FACE_Z_LO] = open_zlo[i];
         if (masks[i] != '0) last_bit = i;
      end
      for (int i = 1; i <= vrfc_pkg::ROW_VOXELS_DEF; i++) begin
         if (masks[i] != '0) begin
            b.voxel_x   = CB'(i - 1);
            b.voxel_y   = r.y;
            b.voxel_z   = r.z;
            b.face_mask = masks[i];
            b.last      = (i == last_bit);
            faces_due.push_back(b);
         end
      end
   endfunction

   // Random bits at a given density in percent
   function automatic logic [RB-1:0] rand_bits(input int pct);
      logic [RB-1:0] v;
      for (int i = 0; i < RB; i++) v[i] = ($urandom_range(99) < pct);
      return v;
   endfunction

   // Neighbor row: random, solid, empty, covering the center, or dense
   function automatic logic [RB-1:0] rand_neighbor(input logic [RB-1:0] c);
      case ($urandom_range(4))
         0:       return RB'($urandom);
         1:       return ROW_FULL;
         2:       return ROW_EMPTY;
         3:       return c | rand_bits(10);
         default: return rand_bits(80);
      endcase
   endfunction

   function automatic row_type rand_row();
      row_type r;
      case ($urandom_range(3))
         0:       r.center = RB'($urandom);
         1:       r.center = rand_bits(85);
         2:       r.center = rand_bits(15);
         default: r.center = rand_bits(50);
      endcase
      r.above  = rand_neighbor(r.center);
      r.below  = rand_neighbor(r.center);
      r.ahead  = rand_neighbor(r.center);
      r.behind = rand_neighbor(r.center);
      r.y      = CB'($urandom_range(15));
      r.z      = CB'($urandom_range(15));
      return r;
   endfunction

   // Offer one row beat; returns right after the edge that takes it
   task automatic offer_row(input row_type r);
      @(negedge clock);
      while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {6'b0, r.z, r.y, r.behind, r.ahead, r.below, r.above, r.center};
      req_tvalid <= 1'b1;
      // results cannot come before the beat is taken, so queue them now
      predict_faces(r);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic offer_plain(input logic [RB-1:0] c,
                              input logic [RB-1:0] a,
                              input logic [RB-1:0] b,
                              input logic [RB-1:0] h,
                              input logic [RB-1:0] bh,
                              input logic [CB-1:0] y,
                              input logic [CB-1:0] z);
      row_type r;
      r.center = c;
      r.above  = a;
      r.below  = b;
      r.ahead  = h;
      r.behind = bh;
      r.y      = y;
      r.z      = z;
      offer_row(r);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Switch idling on each side; optionally start a long receiver hold
   task automatic set_phase(input bit tx_idle, input bit rx_idle, input int hold);
      @(posedge clock);
      tx_idle_on = tx_idle;
      rx_idle_on = rx_idle;
      if (hold > 0) begin
         hold_len = hold;
         hold_requests++;
      end
   endtask

   task automatic test_directed();
      set_phase(1'b1, 1'b1, 0);
      // empty row, then a solid block with nothing exposed
      offer_plain(ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, 4'd0, 4'd0);
      offer_plain(ROW_FULL, ROW_FULL, ROW_FULL, ROW_FULL, ROW_FULL, 4'd15, 4'd15);
      // solid row in empty space: sixteen voxels, y and z faces
      offer_plain(ROW_FULL, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, 4'd15, 4'd0);
      // no padding: only the two end x faces show
      offer_plain(18'h1FFFE, ROW_FULL, ROW_FULL, ROW_FULL, ROW_FULL, 4'd0, 4'd15);
      // padding bits only in the center: never voxels
      offer_plain(18'h20001, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, 4'd7, 4'd8);
      // single voxels at both ends, fully open
      offer_plain(18'h00002, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, 4'd0, 4'd15);
      offer_plain(18'h10000, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, ROW_EMPTY, 4'd15, 4'd0);
      // checkerboards
      offer_plain(18'h2AAAA, ROW_FULL, ROW_FULL, ROW_FULL, ROW_FULL, 4'd5, 4'd10);
      offer_plain(18'h15555, ROW_FULL, ROW_FULL, ROW_FULL, ROW_FULL, 4'd10, 4'd5);
      // run of three, middle one enclosed
      offer_plain(18'h000E0, 18'h000E0, 18'h000E0, 18'h000E0, 18'h000E0, 4'd3, 4'd12);
      // neighbor padding set but interior empty: padding is ignored
      offer_plain(18'h1FFFE, 18'h20001, 18'h20001, 18'h20001, 18'h20001, 4'd9, 4'd6);
      // one open face direction at a time
      offer_plain(ROW_FULL, ROW_EMPTY, ROW_FULL, ROW_FULL, ROW_FULL, 4'd1, 4'd2);
      offer_plain(ROW_FULL, ROW_FULL, ROW_EMPTY, ROW_FULL, ROW_FULL, 4'd2, 4'd1);
      offer_plain(ROW_FULL, ROW_FULL, ROW_FULL, ROW_EMPTY, ROW_FULL, 4'd14, 4'd13);
      offer_plain(ROW_FULL, ROW_FULL, ROW_FULL, ROW_FULL, ROW_EMPTY, 4'd13, 4'd14);
      // scattered center against mixed neighbors
      offer_plain(18'h24921, ROW_FULL, ROW_EMPTY, 18'h24921, ROW_FULL, 4'd6, 4'd9);
      end_burst();
   endtask

   task automatic test_random_mixed();
      set_phase(1'b1, 1'b1, 0);
      repeat (180) offer_row(rand_row());
      end_burst();
   endtask

   // Receiver holds off while rows keep coming, so the input must stall
   task automatic test_back_pressure();
      set_phase(1'b0, 1'b0, HOLD_CYCLES);
      repeat (40) offer_row(rand_row());
      end_burst();
   endtask

   task automatic test_streaming();
      set_phase(1'b0, 1'b0, 0);
      repeat (120) offer_row(rand_row());
      end_burst();
   endtask

   task automatic test_random_tail();
      set_phase(1'b1, 1'b1, 0);
      repeat (120) offer_row(rand_row());
      end_burst();
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         fault_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Result checker: each taken beat against the oldest expectation
   always @(posedge clock) begin
      vrfc_pkg::beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (faces_due.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected beat, expected none, actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = faces_due.pop_front();
            check_field("voxel_x", int'(want.voxel_x), int'(rsp_tdata[3:0]));
            check_field("voxel_y", int'(want.voxel_y), int'(rsp_tdata[7:4]));
            check_field("voxel_z", int'(want.voxel_z), int'(rsp_tdata[11:8]));
            check_field("face_mask", int'(want.face_mask), int'(rsp_tdata[17:12]));
            check_field("pad", 0, int'(rsp_tdata[vrfc_pkg::RSP_DATA_BITS-1:18]));
            check_field("last", int'(want.last), int'(rsp_tlast));
         end
      end
   end

   // Receiver: random stalls, plus long holds on request
   initial begin
      int hold_left;
      int hold_seen;
      hold_left  = 0;
      hold_seen  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_idle_on) begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_voxel_row_face_culler_core: errors");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mixed();
      test_back_pressure();
      test_streaming();
      test_random_tail();

      // drain, then let the pipeline settle
      while (faces_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && faces_due.size() == 0) begin
         $display("tb_voxel_row_face_culler_core: clean");
      end else begin
         $display("tb_voxel_row_face_culler_core: errors");
      end
      $finish;
   end

endmodule
